// ===== sv/frame_checker_crc16_error_level_defines.svh =====
// Assertion macros for the frame checker with CRC-16 and error level.
// Included by the top level; depends on nothing else.
`ifndef FRAME_CHECKER_CRC16_ERROR_LEVEL_DEFINES_SVH
`define FRAME_CHECKER_CRC16_ERROR_LEVEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FCK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fck_pkg.sv =====
// Shared types, constants and the byte-wide CRC-16 update of the frame checker.
// Depends on nothing; the modules and the testbench import it.
`default_nettype none

package fck_pkg;

    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_SHORT  = 2'd1,
        ST_HEADER = 2'd2,
        ST_CRC    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_HEADER  = 2'd0,
        CFG_PENALTY = 2'd1,
        CFG_CEILING = 2'd2
    } t_cfg_index;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  CMD_LIMIT     = 8'hF0;
    localparam logic [7:0]  HEADER_RESET  = 8'hA5;
    localparam logic [7:0]  PENALTY_RESET = 8'd2;
    localparam logic [7:0]  CEILING_RESET = 8'd10;

    typedef struct packed {
        logic [7:0] header;
        logic [7:0] penalty;
        logic [7:0] ceiling;
    } t_cfg;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_item;

    // Reflected CRC-16 update over one byte, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fck_channels.sv =====
// Handshake channel interfaces: received items, check results and register writes.
// Depends on nothing.
`default_nettype none

interface fck_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface fck_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       frame_accepted;
    logic [7:0] command;
    logic [7:0] payload_0;
    logic [7:0] payload_1;
    logic [7:0] payload_2;
    logic [7:0] payload_3;
    logic [7:0] error_level;

    modport source (output valid, output status, output frame_accepted, output command,
                    output payload_0, output payload_1, output payload_2,
                    output payload_3, output error_level, input ready);
    modport sink (input valid, input status, input frame_accepted, input command,
                  input payload_0, input payload_1, input payload_2,
                  input payload_3, input error_level, output ready);
endinterface

interface fck_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/fck_cfg_regs.sv =====
// Configuration registers: frame header, error penalty and error ceiling.
// Depends on fck_pkg and fck_cfg_if.
`default_nettype none

module fck_cfg_regs import fck_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fck_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header  <= HEADER_RESET;
            r_cfg.penalty <= PENALTY_RESET;
            r_cfg.ceiling <= CEILING_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_HEADER:  r_cfg.header  <= i_cfg.data;
                CFG_PENALTY: r_cfg.penalty <= i_cfg.data;
                CFG_CEILING: r_cfg.ceiling <= i_cfg.data;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/fck_in_reg.sv =====
// Input register: holds one received item until the frame check takes it.
// Depends on fck_pkg and fck_in_if.
`default_nettype none

module fck_in_reg import fck_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fck_in_if.sink     i_in,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_accept;

    assign i_in.ready = !r_valid || i_take;
    assign w_accept   = i_in.valid && i_in.ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action  <= i_in.action;
            r_item.rx_byte <= i_in.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fck_frame_check.sv =====
// Frame state, CRC-16 update, frame-end check, error level and result register.
// Depends on fck_pkg and fck_out_if.
`default_nettype none

module fck_frame_check import fck_pkg::*; #(
    parameter int FRAME_LENGTH = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_item_valid,
    input  wire t_item i_item,
    output logic       o_take,
    fck_out_if.source  o_out
);

    localparam int CW = $clog2(FRAME_LENGTH + 1);
    localparam int IW = $clog2(FRAME_LENGTH);

    logic [7:0]    r_bytes [FRAME_LENGTH];
    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic [7:0]    r_link;
    logic          r_out_valid;
    t_status       r_status;
    logic          r_accepted;
    logic [7:0]    r_command;
    logic [7:0]    r_payload [4];

    logic [7:0]    w_kept [5];
    logic          w_full;
    logic [15:0]   w_rx_crc;
    logic [8:0]    w_sum;
    logic          w_store;
    logic          w_end;
    t_status       n_status;
    logic [7:0]    n_link;

    genvar g;
    for (g = 0; g < 5; g++) begin : g_kept
        if (g + 1 < FRAME_LENGTH) begin : g_on
            assign w_kept[g] = (r_count > CW'(g + 1)) ? r_bytes[g + 1] : 8'h00;
        end else begin : g_off
            assign w_kept[g] = 8'h00;
        end
    end

    assign w_full   = (r_count == CW'(FRAME_LENGTH));
    assign w_rx_crc = {r_bytes[FRAME_LENGTH - 1], r_bytes[FRAME_LENGTH - 2]};
    assign w_sum    = {1'b0, r_link} + {1'b0, i_cfg.penalty};
    assign o_take   = i_item_valid && (!i_item.action || !r_out_valid || o_out.ready);
    assign w_store  = o_take && !i_item.action && !w_full;
    assign w_end    = o_take && i_item.action;

    always_comb begin
        if (!w_full) begin
            n_status = ST_SHORT;
        end else if (r_bytes[0] != i_cfg.header) begin
            n_status = ST_HEADER;
        end else if (w_rx_crc == r_crc) begin
            n_status = ST_GOOD;
        end else begin
            n_status = ST_CRC;
        end

        if (n_status == ST_GOOD) begin
            n_link = (r_link != 8'h00) ? (r_link - 8'd1) : r_link;
        end else if (w_sum >= {1'b0, i_cfg.ceiling}) begin
            n_link = i_cfg.ceiling;
        end else begin
            n_link = w_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_link      <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (w_store) begin
                r_count <= r_count + CW'(1);
                if (r_count < CW'(FRAME_LENGTH - 2)) begin
                    r_crc <= crc_byte(r_crc, i_item.rx_byte);
                end
            end
            if (w_end) begin
                r_count     <= '0;
                r_crc       <= CRC_INIT;
                r_link      <= n_link;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_bytes[r_count[IW-1:0]] <= i_item.rx_byte;
        end
        if (w_end) begin
            r_status   <= n_status;
            r_accepted <= (n_status == ST_GOOD) && (w_kept[0] < CMD_LIMIT);
            r_command  <= w_kept[0];
            for (int k = 0; k < 4; k++) begin
                r_payload[k] <= w_kept[k + 1];
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.frame_accepted = r_accepted;
    assign o_out.command        = r_command;
    assign o_out.payload_0      = r_payload[0];
    assign o_out.payload_1      = r_payload[1];
    assign o_out.payload_2      = r_payload[2];
    assign o_out.payload_3      = r_payload[3];
    assign o_out.error_level    = r_link;

endmodule

`default_nettype wire

// ===== sv/frame_checker_crc16_error_level.sv =====
// Frame checker top level: CRC-16 (0xA001) frame check with saturating error level.
// A frame-end transfer goes through the input register, then the result register.
// Throughput: one item per cycle while no frame end waits on an untaken result; the CRC
// byte update and the frame-end check each fit between the two registers.
// Reset (synchronous, active low) clears byte count, CRC, error level and valids.
// Depends on fck_pkg, fck_channels, fck_cfg_regs, fck_in_reg and fck_frame_check.
`default_nettype none
`include "frame_checker_crc16_error_level_defines.svh"

module frame_checker_crc16_error_level import fck_pkg::*; #(
    parameter int FRAME_LENGTH = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fck_in_if.sink     i_in,
    fck_out_if.source  o_out,
    fck_cfg_if.sink    i_cfg
);

    t_cfg  w_cfg;
    logic  w_item_valid;
    t_item w_item;
    logic  w_take;

    fck_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    fck_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    fck_frame_check #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .o_out        (o_out)
    );

    `FCK_ASSERT_IMPL(a_accept_good, i_clk, i_rst_n, o_out.valid && o_out.frame_accepted, o_out.status == ST_GOOD && o_out.command < CMD_LIMIT, "accepted frame without good status")
    `FCK_ASSERT_NEXT(a_end_result, i_clk, i_rst_n, w_take && w_item.action, o_out.valid, "frame end did not produce a result")
    `FCK_ASSERT_IMPL(a_ready_hold, i_clk, i_rst_n, !i_in.ready, w_item_valid, "input stalled with empty input register")

endmodule

`default_nettype wire

// ===== verif/frame_checker_crc16_error_level_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for frame_checker_crc16_error_level: sends received bytes and
// frame-end marks, predicts each frame status, payload and error level, and compares them.
// Depends on fck_pkg, fck_channels and the frame checker RTL.
module frame_checker_crc16_error_level_tb;
    import fck_pkg::*;

    localparam int FRAME_LEN = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 340;
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END = 1'b1;

    typedef struct packed {
        t_status         status;
        logic            accepted;
        logic [7:0]      command;
        logic [3:0][7:0] payload;
        logic [7:0]      level;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;

    fck_in_if  in_ch ();
    fck_out_if out_ch ();
    fck_cfg_if cfg_ch ();

    frame_checker_crc16_error_level #(
        .FRAME_LENGTH(FRAME_LEN)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    logic [7:0]    kept_bytes [FRAME_LEN];
    int            kept_count;
    logic [15:0]   crc_acc;
    logic [7:0]    level;
    t_cfg          cfg_shadow;
    t_frame_result pending_results [$];
    logic [7:0]    frame_buf [$];
    int            mismatch_count;
    int            items_sent;
    int            quiet_cycles;
    bit            idling_on;
    bit            sender_gappy;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] rnd_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            fb = acc[0] ^ data[i];
            acc = acc >> 1;
            if (fb) acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    function automatic logic [7:0] kept_at(input int idx);
        if (idx < kept_count && idx < FRAME_LEN) return kept_bytes[idx];
        return 8'h00;
    endfunction

    function automatic void track_rx_item(input logic action, input logic [7:0] rx);
        t_frame_result r;
        logic [15:0]   sent_crc;
        logic [8:0]    raised;
        if (action == ACT_BYTE) begin
            if (kept_count < FRAME_LEN) begin
                kept_bytes[kept_count] = rx;
                if (kept_count + 2 < FRAME_LEN) crc_acc = crc16_update(crc_acc, rx);
                kept_count++;
            end
        end else begin
            if (kept_count < FRAME_LEN) begin
                r.status = ST_SHORT;
            end else if (kept_bytes[0] != cfg_shadow.header) begin
                r.status = ST_HEADER;
            end else begin
                sent_crc = {kept_bytes[FRAME_LEN-1], kept_bytes[FRAME_LEN-2]};
                r.status = (sent_crc == crc_acc) ? ST_GOOD : ST_CRC;
            end
            if (r.status == ST_GOOD) begin
                if (level != 8'd0) level = level - 8'd1;
            end else begin
                raised = {1'b0, level} + {1'b0, cfg_shadow.penalty};
                if (raised >= {1'b0, cfg_shadow.ceiling}) level = cfg_shadow.ceiling;
                else level = raised[7:0];
            end
            r.command = kept_at(1);
            r.accepted = (r.status == ST_GOOD) && (r.command < CMD_LIMIT);
            for (int k = 0; k < 4; k++) r.payload[k] = kept_at(2 + k);
            r.level = level;
            pending_results.push_back(r);
            kept_count = 0;
            crc_acc = CRC_INIT;
        end
    endfunction

    task automatic send_item(input logic action, input logic [7:0] rx);
        if (sender_gappy && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= action;
        in_ch.rx_byte <= rx;
        do @(posedge i_clk); while (!in_ch.ready);
        track_rx_item(action, rx);
        items_sent++;
    endtask

    task automatic send_frame_buf();
        foreach (frame_buf[i]) send_item(ACT_BYTE, frame_buf[i]);
        send_item(ACT_END, rnd_byte());
        frame_buf.delete();
    endtask

    task automatic build_frame(input logic [7:0] header, input logic [7:0] cmd,
                               input logic [7:0] p0, input logic [7:0] p1,
                               input logic [7:0] p2, input logic [7:0] p3,
                               input logic [15:0] crc_flip);
        logic [15:0] crc;
        frame_buf.delete();
        frame_buf.push_back(header);
        frame_buf.push_back(cmd);
        frame_buf.push_back(p0);
        frame_buf.push_back(p1);
        frame_buf.push_back(p2);
        frame_buf.push_back(p3);
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) crc = crc16_update(crc, frame_buf[i]);
        crc = crc ^ crc_flip;
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_config(input logic [7:0] header, input logic [7:0] penalty,
                                input logic [7:0] ceiling);
        t_cfg_index regs [3] = '{CFG_HEADER, CFG_PENALTY, CFG_CEILING};
        logic [7:0] vals [3];
        vals[0] = header;
        vals[1] = penalty;
        vals[2] = ceiling;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (int i = 0; i < 3; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data <= vals[i];
            do @(posedge i_clk); while (!cfg_ch.ready);
            case (regs[i])
                CFG_HEADER: cfg_shadow.header = vals[i];
                CFG_PENALTY: cfg_shadow.penalty = vals[i];
                default: cfg_shadow.ceiling = vals[i];
            endcase
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_frame();
        int          kind;
        logic [7:0]  cmd;
        logic [7:0]  flip;
        logic [31:0] r;
        sender_gappy = idling_on && ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 19) == 0) drain_results();
        kind = $urandom_range(0, 9);
        r = $urandom;
        cmd = ($urandom_range(0, 3) == 0) ? (CMD_LIMIT | {4'h0, r[3:0]}) : rnd_byte();
        if (kind <= 5) begin
            build_frame(cfg_shadow.header, cmd, rnd_byte(), rnd_byte(), rnd_byte(),
                        rnd_byte(), 16'h0000);
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) frame_buf.push_back(rnd_byte());
            end
        end else if (kind == 6) begin
            build_frame(cfg_shadow.header, cmd, rnd_byte(), rnd_byte(), rnd_byte(),
                        rnd_byte(), 16'h0001 << r[7:4]);
        end else if (kind == 7) begin
            flip = rnd_byte();
            if (flip == 8'h00) flip = 8'h01;
            build_frame(cfg_shadow.header ^ flip, cmd, rnd_byte(), rnd_byte(), rnd_byte(),
                        rnd_byte(), 16'h0000);
        end else if (kind == 8) begin
            frame_buf.delete();
            if ($urandom_range(0, 7) != 0) frame_buf.push_back(cfg_shadow.header);
            repeat ($urandom_range(0, 6)) frame_buf.push_back(rnd_byte());
        end else begin
            frame_buf.delete();
            repeat ($urandom_range(1, 12)) frame_buf.push_back(rnd_byte());
        end
        send_frame_buf();
    endtask

    task automatic test_short_frames();
        send_item(ACT_END, 8'hFF);
        frame_buf.delete();
        frame_buf.push_back(HEADER_RESET);
        frame_buf.push_back(8'h12);
        send_frame_buf();
    endtask

    task automatic test_good_frames();
        build_frame(HEADER_RESET, 8'hEF, 8'h00, 8'hFF, 8'h00, 8'hFF, 16'h0000);
        send_frame_buf();
        build_frame(HEADER_RESET, CMD_LIMIT, 8'hFF, 8'h00, 8'h80, 8'h01, 16'h0000);
        frame_buf.push_back(8'hFF);
        frame_buf.push_back(8'h00);
        send_frame_buf();
    endtask

    task automatic test_bad_frames();
        build_frame(~HEADER_RESET, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 16'h0000);
        send_frame_buf();
        build_frame(HEADER_RESET, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 16'h8000);
        send_frame_buf();
    endtask

    task automatic test_error_level_limits();
        write_config(8'hFF, 8'hFF, 8'hFF);
        send_item(ACT_END, 8'h00);
        send_item(ACT_END, 8'h00);
        write_config(8'hFF, 8'hFF, 8'h00);
        send_item(ACT_END, 8'h00);
        build_frame(8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_frame_buf();
    endtask

    task automatic test_random_traffic(input logic [7:0] header, input logic [7:0] penalty,
                                       input logic [7:0] ceiling, input bit idle);
        int stop_at;
        write_config(header, penalty, ceiling);
        idling_on = idle;
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) send_random_frame();
    endtask

    initial begin : result_ready_driver
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) stall_left--;
            else if (idling_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 10);
            out_ch.ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.status = t_status'(out_ch.status);
            got.accepted = out_ch.frame_accepted;
            got.command = out_ch.command;
            got.payload = {out_ch.payload_3, out_ch.payload_2, out_ch.payload_1,
                           out_ch.payload_0};
            got.level = out_ch.error_level;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no frame end pending: %p", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: result mismatch", $realtime);
                        $display("  expected status=%0d acc=%0b cmd=%h pay=%h level=%0d",
                                 want.status, want.accepted, want.command, want.payload,
                                 want.level);
                        $display("  actual   status=%0d acc=%0b cmd=%h pay=%h level=%0d",
                                 got.status, got.accepted, got.command, got.payload,
                                 got.level);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("frame_checker_crc16_error_level test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        mismatch_count = 0;
        items_sent = 0;
        quiet_cycles = 0;
        idling_on = 1'b1;
        sender_gappy = 1'b1;
        kept_count = 0;
        crc_acc = CRC_INIT;
        level = 8'd0;
        cfg_shadow.header = HEADER_RESET;
        cfg_shadow.penalty = PENALTY_RESET;
        cfg_shadow.ceiling = CEILING_RESET;
        in_ch.valid <= 1'b0;
        in_ch.action <= ACT_BYTE;
        in_ch.rx_byte <= 8'h00;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_HEADER;
        cfg_ch.data <= 8'h00;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frames();
        test_good_frames();
        test_bad_frames();
        test_error_level_limits();
        test_random_traffic(rnd_byte(), rnd_byte() & 8'h0F, rnd_byte(), 1'b1);
        test_random_traffic(8'h00, 8'h00, 8'h00, 1'b1);
        test_random_traffic(8'hFF, 8'hFF, 8'hFF, 1'b1);
        test_random_traffic(8'h5A, 8'h01, 8'hFF, 1'b1);
        test_random_traffic(HEADER_RESET, PENALTY_RESET, CEILING_RESET, 1'b0);

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("frame_checker_crc16_error_level test passed");
        end else begin
            $display("frame_checker_crc16_error_level test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fck_pkg.sv
sv/fck_channels.sv
sv/fck_cfg_regs.sv
sv/fck_in_reg.sv
sv/fck_frame_check.sv
sv/frame_checker_crc16_error_level.sv
verif/frame_checker_crc16_error_level_tb.sv
